/* rtl/ffpa_pkg.sv */
// Package with the shared constants, codes and types of the first-fit allocator.
package ffpa_pkg;

    localparam int MEM_SIZE   = 4096;
    localparam int USED_DEPTH = 64;
    localparam int FREE_DEPTH = USED_DEPTH + 1;

    localparam int AW = 12;   // address width
    localparam int SW = 13;   // size width (holds MEM_SIZE)
    localparam int FIW = 7;   // free-table index and count width
    localparam int UIW = 6;   // used-table index width
    localparam int UCW = 7;   // used-table count width

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE = 3'd1;
    localparam logic [2:0] ST_NO_FREE  = 3'd2;
    localparam logic [2:0] ST_NO_FIT   = 3'd3;
    localparam logic [2:0] ST_BAD_POS  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // One table entry: start address and size.
    typedef struct packed {
        logic [AW-1:0] start;
        logic [SW-1:0] size;
    } part_t;

endpackage

/* rtl/first_fit_partition_allocator_unit.sv */
// Top level of the first-fit variable-partition allocator with coalescing.
//
//  channel   ports                                            timing
//  command   start, busy, cmd, request_size, used_position    taken when start & !busy
//  result    done, status, block_address, block_position,     one cycle, one per command
//            free_entries
//
// Both tables are RAMs with one registered read and one write per cycle. A command walks
// them one entry per cycle. An allocate scans k + 1 free entries, then shifts the free
// table on an exact fit. A release reads its block, closes the used-table gap, scans the
// free table, then merges or shifts.
// After reset an initialization state writes the single free partition, with busy high.
// Results cannot be stalled; busy stays high until the result cycle has ended.
module first_fit_partition_allocator_unit
    import ffpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                cmd,
    input  logic [12:0]         request_size,
    input  logic [6:0]          used_position,
    output logic                done,
    output logic [2:0]          status,
    output logic [11:0]         block_address,
    output logic [5:0]          block_position,
    output logic [6:0]          free_entries
);

    typedef enum logic [9:0] {
        S_INIT   = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_ASCAN  = 10'b0000000100,
        S_URD    = 10'b0000001000,
        S_USHIFT = 10'b0000010000,
        S_RSCAN  = 10'b0000100000,
        S_FDOWN  = 10'b0001000000,
        S_FPREP  = 10'b0010000000,
        S_FUP    = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg;

    // Table storage: one registered read port and one write port each.
    part_t free_mem [FREE_DEPTH];
    part_t used_mem [USED_DEPTH];
    part_t free_rd_reg;
    part_t used_rd_reg;

    logic [FIW-1:0] free_raddr;
    logic [FIW-1:0] free_waddr;
    part_t          free_wdata;
    logic           free_we;
    logic [FIW-1:0] used_rsum;
    logic [UIW-1:0] used_raddr;
    logic [UIW-1:0] used_waddr;
    part_t          used_wdata;
    logic           used_we;

    logic [FIW-1:0] free_cnt_reg;
    logic [UCW-1:0] used_cnt_reg;
    logic [FIW-1:0] idx_reg;
    logic [FIW-1:0] kins_reg;
    logic [SW-1:0]  req_reg;
    logic [AW-1:0]  a_reg;
    logic [SW-1:0]  z_reg;
    part_t          prv_reg;
    logic [2:0]     status_reg;
    logic [AW-1:0]  addr_reg;
    logic [5:0]     bpos_reg;
    logic           done_reg;
    logic           accept;

    // Compare flags against the entry that was read for idx_reg.
    logic fit, exact, last_free, used_full, in_range, scan_stop, pred, succ;
    assign accept    = start && !busy;
    assign fit       = (free_rd_reg.size >= req_reg);
    assign exact     = (free_rd_reg.size == req_reg);
    assign last_free = (idx_reg + 7'd1 >= free_cnt_reg);
    assign used_full = (used_cnt_reg >= UCW'(USED_DEPTH));
    assign in_range  = (idx_reg < free_cnt_reg);
    assign scan_stop = !in_range || (free_rd_reg.start > a_reg);
    assign pred      = (idx_reg != '0) &&
                       ({2'b00, prv_reg.start} + {1'b0, prv_reg.size} == {2'b00, a_reg});
    assign succ      = in_range &&
                       ({2'b00, a_reg} + {1'b0, z_reg} == {2'b00, free_rd_reg.start});

    // Read addresses lead the sequencer index: one entry in scans, two in shifts.
    always_comb
    begin
        free_raddr = '0;
        used_rsum  = '0;
        case (state_reg)
            S_IDLE:   used_rsum  = {1'b0, used_position[UIW-1:0]};
            S_ASCAN:  free_raddr = idx_reg + 7'd1;
            S_URD:    used_rsum  = idx_reg + 7'd1;
            S_USHIFT: used_rsum  = idx_reg + 7'd2;
            S_RSCAN:  free_raddr = idx_reg + 7'd1;
            S_FDOWN:  free_raddr = idx_reg + 7'd2;
            S_FPREP:  free_raddr = idx_reg - 7'd1;
            S_FUP:    free_raddr = idx_reg - 7'd2;
            default:  ;
        endcase
    end
    assign used_raddr = used_rsum[UIW-1:0];

    // Table writes decoded from the sequencer state.
    always_comb
    begin
        free_we    = 1'b0;
        free_waddr = idx_reg;
        free_wdata = free_rd_reg;
        used_we    = 1'b0;
        used_waddr = used_cnt_reg[UIW-1:0];
        used_wdata = '{start: free_rd_reg.start, size: req_reg};
        case (state_reg)
            S_INIT:
            begin
                free_we    = 1'b1;
                free_waddr = '0;
                free_wdata = '{start: '0, size: SW'(MEM_SIZE)};
            end
            S_ASCAN:
            begin
                if (fit && !used_full)
                begin
                    used_we = 1'b1;
                    if (!exact)
                    begin
                        free_we    = 1'b1;
                        free_wdata = '{start: free_rd_reg.start + req_reg[AW-1:0],
                                       size: free_rd_reg.size - req_reg};
                    end
                end
            end
            S_USHIFT:
            begin
                if (idx_reg + 7'd1 < used_cnt_reg)
                begin
                    used_we    = 1'b1;
                    used_waddr = idx_reg[UIW-1:0];
                    used_wdata = used_rd_reg;
                end
            end
            S_RSCAN:
            begin
                if (scan_stop)
                begin
                    if (pred)
                    begin
                        free_we    = 1'b1;
                        free_waddr = idx_reg - 7'd1;
                        free_wdata = '{start: prv_reg.start,
                                       size: succ ? prv_reg.size + z_reg + free_rd_reg.size
                                                  : prv_reg.size + z_reg};
                    end
                    else if (succ)
                    begin
                        free_we    = 1'b1;
                        free_wdata = '{start: a_reg, size: free_rd_reg.size + z_reg};
                    end
                end
            end
            S_FDOWN:
            begin
                if (idx_reg < free_cnt_reg)
                    free_we = 1'b1;
            end
            S_FUP:
            begin
                free_we = 1'b1;
                if (idx_reg <= kins_reg)
                    free_wdata = '{start: a_reg, size: z_reg};
            end
            default: ;
        endcase
    end

    // Free table RAM.
    always_ff @(posedge clk)
    begin
        if (free_we)
            free_mem[free_waddr] <= free_wdata;
        free_rd_reg <= free_mem[free_raddr];
    end

    // Used table RAM.
    always_ff @(posedge clk)
    begin
        if (used_we)
            used_mem[used_waddr] <= used_wdata;
        used_rd_reg <= used_mem[used_raddr];
    end

    // Sequencer and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            free_cnt_reg <= 7'd1;
            used_cnt_reg <= '0;
            done_reg     <= 1'b0;
            idx_reg      <= '0;
            kins_reg     <= '0;
            req_reg      <= '0;
            a_reg        <= '0;
            z_reg        <= '0;
            prv_reg      <= '0;
            status_reg   <= ST_OK;
            addr_reg     <= '0;
            bpos_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                    state_reg <= S_IDLE;
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg    <= request_size;
                        idx_reg    <= '0;
                        addr_reg   <= '0;
                        bpos_reg   <= '0;
                        status_reg <= ST_OK;
                        if (cmd == CMD_ALLOC)
                        begin
                            if (request_size == '0 || request_size > SW'(MEM_SIZE))
                            begin
                                status_reg <= ST_BAD_SIZE;
                                state_reg  <= S_DONE;
                            end
                            else if (free_cnt_reg == '0)
                            begin
                                status_reg <= ST_NO_FREE;
                                state_reg  <= S_DONE;
                            end
                            else
                                state_reg <= S_ASCAN;
                        end
                        else if (used_position >= used_cnt_reg)
                        begin
                            status_reg <= ST_BAD_POS;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            idx_reg   <= used_position;
                            state_reg <= S_URD;
                        end
                    end
                end
                S_ASCAN:
                begin
                    if (fit)
                    begin
                        if (used_full)
                        begin
                            status_reg <= ST_FULL;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            addr_reg     <= free_rd_reg.start;
                            bpos_reg     <= used_cnt_reg[UIW-1:0];
                            used_cnt_reg <= used_cnt_reg + 7'd1;
                            if (exact)
                            begin
                                free_cnt_reg <= free_cnt_reg - 7'd1;
                                state_reg    <= S_FDOWN;
                            end
                            else
                                state_reg <= S_DONE;
                        end
                    end
                    else if (last_free)
                    begin
                        status_reg <= ST_NO_FIT;
                        state_reg  <= S_DONE;
                    end
                    else
                        idx_reg <= idx_reg + 7'd1;
                end
                S_URD:
                begin
                    a_reg     <= used_rd_reg.start;
                    z_reg     <= used_rd_reg.size;
                    addr_reg  <= used_rd_reg.start;
                    state_reg <= S_USHIFT;
                end
                S_USHIFT:
                begin
                    // Close the gap in the used table one entry per cycle.
                    if (idx_reg + 7'd1 < used_cnt_reg)
                        idx_reg <= idx_reg + 7'd1;
                    else
                    begin
                        used_cnt_reg <= used_cnt_reg - 7'd1;
                        idx_reg      <= '0;
                        state_reg    <= S_RSCAN;
                    end
                end
                S_RSCAN:
                begin
                    // Find the first free entry above the block, keeping its predecessor.
                    if (scan_stop)
                    begin
                        if (pred && succ)
                        begin
                            free_cnt_reg <= free_cnt_reg - 7'd1;
                            state_reg    <= S_FDOWN;
                        end
                        else if (pred || succ)
                            state_reg <= S_DONE;
                        else if (free_cnt_reg >= FIW'(FREE_DEPTH))
                            state_reg <= S_DONE;
                        else
                        begin
                            kins_reg  <= idx_reg;
                            idx_reg   <= free_cnt_reg;
                            state_reg <= S_FPREP;
                        end
                    end
                    else
                    begin
                        prv_reg <= free_rd_reg;
                        idx_reg <= idx_reg + 7'd1;
                    end
                end
                S_FDOWN:
                begin
                    // free_cnt_reg already holds the new count.
                    if (idx_reg < free_cnt_reg)
                        idx_reg <= idx_reg + 7'd1;
                    else
                        state_reg <= S_DONE;
                end
                S_FPREP:
                    state_reg <= S_FUP;
                S_FUP:
                begin
                    // Open a hole at the insertion point by moving entries up from the top.
                    if (idx_reg > kins_reg)
                        idx_reg <= idx_reg - 7'd1;
                    else
                    begin
                        free_cnt_reg <= free_cnt_reg + 7'd1;
                        state_reg    <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE) || done_reg;
    assign done           = done_reg;
    assign status         = status_reg;
    assign block_address  = addr_reg;
    assign block_position = bpos_reg;
    assign free_entries   = free_cnt_reg;

`ifndef SYNTHESIS
    // The free table never holds more entries than it has rows.
    assert property (@(posedge clk) disable iff (!rst_n) free_cnt_reg <= FIW'(FREE_DEPTH))
        else $error("free count overflow");
    // The used table never holds more entries than it has rows.
    assert property (@(posedge clk) disable iff (!rst_n) used_cnt_reg <= UCW'(USED_DEPTH))
        else $error("used count overflow");
    // A result is only raised after the final sequencer step.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(state_reg) == S_DONE)
        else $error("result without completion");
`endif

endmodule

/* dv/ffpa_checker.sv */
// Checker that predicts allocator results from observed commands and compares them.
module ffpa_checker
    import ffpa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         busy,
    input  logic         cmd,
    input  logic [12:0]  request_size,
    input  logic [6:0]   used_position,
    input  logic         done,
    input  logic [2:0]   status,
    input  logic [11:0]  block_address,
    input  logic [5:0]   block_position,
    input  logic [6:0]   free_entries,
    output int           error_count,
    output int           pending,
    output int           used_blocks
);

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] addr;
        logic [5:0]  bpos;
        logic [6:0]  nfree;
    } outcome_t;

    // Shadow copy of the allocator tables.
    int free_base [FREE_DEPTH];
    int free_len  [FREE_DEPTH];
    int n_free;
    int used_base [USED_DEPTH];
    int used_len  [USED_DEPTH];
    int n_used;
    outcome_t outcome_q[$];

    assign used_blocks = n_used;

    // Remove free partition k, closing the gap.
    function automatic void drop_part(int k);
        for (int i = k; i + 1 < n_free; i++)
        begin
            free_base[i] = free_base[i+1];
            free_len[i]  = free_len[i+1];
        end
        if (n_free > 0)
            n_free--;
    endfunction

    // Insert a free partition at index k when room is left.
    function automatic void add_part(int k, int a, int z);
        if (n_free >= FREE_DEPTH || k > n_free)
            return;
        for (int i = n_free; i > k; i--)
        begin
            free_base[i] = free_base[i-1];
            free_len[i]  = free_len[i-1];
        end
        free_base[k] = a;
        free_len[k]  = z;
        n_free++;
    endfunction

    // Predict one command and update the shadow tables.
    function automatic outcome_t apply_command(logic c, int req, int pos);
        outcome_t o;
        int k;
        int a;
        int z;
        bit found;
        bit lo;
        bit hi;
        o = '0;
        if (c == CMD_ALLOC)
        begin
            if (req == 0 || req > MEM_SIZE)
                o.status = ST_BAD_SIZE;
            else if (n_free == 0)
                o.status = ST_NO_FREE;
            else
            begin
                found = 0;
                for (k = 0; k < n_free; k++)
                begin
                    if (free_len[k] >= req)
                    begin
                        found = 1;
                        break;
                    end
                end
                if (!found)
                    o.status = ST_NO_FIT;
                else if (n_used >= USED_DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    o.addr = 12'(free_base[k]);
                    o.bpos = 6'(n_used);
                    used_base[n_used] = free_base[k];
                    used_len[n_used]  = req;
                    n_used++;
                    if (free_len[k] == req)
                        drop_part(k);
                    else
                    begin
                        free_base[k] += req;
                        free_len[k]  -= req;
                    end
                end
            end
        end
        else if (pos >= n_used)
            o.status = ST_BAD_POS;
        else
        begin
            a = used_base[pos];
            z = used_len[pos];
            for (int i = pos; i + 1 < n_used; i++)
            begin
                used_base[i] = used_base[i+1];
                used_len[i]  = used_len[i+1];
            end
            n_used--;
            o.addr = 12'(a);
            for (k = 0; k < n_free; k++)
                if (free_base[k] > a)
                    break;
            lo = k > 0 && free_base[k-1] + free_len[k-1] == a;
            hi = k < n_free && a + z == free_base[k];
            if (lo && hi)
            begin
                free_len[k-1] += z + free_len[k];
                drop_part(k);
            end
            else if (lo)
                free_len[k-1] += z;
            else if (hi)
            begin
                free_base[k] = a;
                free_len[k] += z;
            end
            else
                add_part(k, a, z);
        end
        o.nfree = 7'(n_free);
        return o;
    endfunction

    // Predict on each accepted command, compare on each result strobe.
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        outcome_t got;
        if (!rst_n)
        begin
            n_free = 1;
            free_base[0] = 0;
            free_len[0] = MEM_SIZE;
            n_used = 0;
            error_count <= 0;
            pending <= 0;
            outcome_q.delete();
        end
        else
        begin
            if (done)
            begin
                got = {status, block_address, block_position, free_entries};
                if (outcome_q.size() == 0)
                begin
                    error_count <= error_count + 1;
                    if (error_count < 10)
                        $display("result with no transaction pending: %p", got);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (want != got)
                    begin
                        error_count <= error_count + 1;
                        if (error_count < 10)
                            $display("mismatch: expected %p, actual %p", want, got);
                    end
                end
            end
            if (start && !busy)
                outcome_q = {outcome_q, apply_command(cmd, request_size, used_position)};
            pending <= outcome_q.size();
        end
    end

endmodule

/* dv/tb_top.sv */
// Testbench top: drives allocator commands and gives the verdict.
module tb_top
    import ffpa_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [12:0] request_size;
    logic [6:0]  used_position;
    logic        done;
    logic [2:0]  status;
    logic [11:0] block_address;
    logic [5:0]  block_position;
    logic [6:0]  free_entries;
    int          error_count;
    int          pending;
    int          used_blocks;
    int          quiet_cycles = 0;

    localparam int QUIET_LIMIT = 20000;

    first_fit_partition_allocator_unit dut (.*);

    ffpa_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Watchdog on cycles where no transaction moves on either channel.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT)
        begin
            $display("** first_fit_partition_allocator_unit: FAILED **");
            $finish;
        end
    end

    // Present one command and hold it until accepted; start stays high afterwards.
    task automatic issue(logic c, int req, int pos);
        start         <= 1'b1;
        cmd           <= c;
        request_size  <= 13'(req);
        used_position <= 7'(pos);
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start and wait until every expected result has come.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Random idle burst between commands.
    task automatic maybe_idle(bit allowed);
        if (allowed && $urandom_range(3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    // Draw a mostly well-formed command, biased by table occupancy.
    task automatic random_command(bit allowed);
        int r;
        r = $urandom_range(99);
        if (r < 4)
            issue(CMD_ALLOC, $urandom_range(8191), $urandom_range(127));
        else if (r < 7)
            issue(CMD_RELEASE, $urandom_range(8191), $urandom_range(127));
        else if (r < 55 - (used_blocks > 40 ? 20 : 0))
            issue(CMD_ALLOC, $urandom_range(3) == 0 ? $urandom_range(4096, 1)
                  : $urandom_range(150, 1), $urandom_range(127));
        else
            issue(CMD_RELEASE, $urandom_range(8191),
                  used_blocks > 0 ? $urandom_range(used_blocks - 1) : 0);
        maybe_idle(allowed);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        cmd           = CMD_ALLOC;
        request_size  = '0;
        used_position = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: size extremes, release with nothing allocated.
        issue(CMD_ALLOC, 0, 0);
        issue(CMD_ALLOC, 4097, 127);
        issue(CMD_ALLOC, 8191, 0);
        issue(CMD_RELEASE, 8191, 0);
        // Whole memory, then empty free table, then release it back.
        issue(CMD_ALLOC, 4096, 0);
        issue(CMD_ALLOC, 1, 0);
        issue(CMD_RELEASE, 0, 1);
        issue(CMD_RELEASE, 0, 0);
        // Three blocks; free middle, then outer ones for merges both ways.
        issue(CMD_ALLOC, 100, 0);
        issue(CMD_ALLOC, 200, 0);
        issue(CMD_ALLOC, 300, 0);
        issue(CMD_RELEASE, 0, 1);
        issue(CMD_ALLOC, 5000 - 1000, 0);
        issue(CMD_RELEASE, 0, 0);
        issue(CMD_RELEASE, 0, 1);
        issue(CMD_RELEASE, 0, 0);
        issue(CMD_ALLOC, 3000, 0);
        issue(CMD_ALLOC, 2000, 0);
        issue(CMD_RELEASE, 8191, 127);
        issue(CMD_RELEASE, 0, 0);

        // Hold off until the checker has drained.
        drain();

        // Fill the used table with small blocks to reach the full case.
        for (int i = 0; i < 66; i++)
            issue(CMD_ALLOC, $urandom_range(40, 1), $urandom_range(127));
        for (int i = 0; i < 40; i++)
            issue(CMD_RELEASE, $urandom, $urandom_range(used_blocks > 0 ? used_blocks - 1 : 0));

        // Random part with idling, then a stretch without.
        for (int i = 0; i < 700; i++)
            random_command(1'b1);
        for (int i = 0; i < 100; i++)
            random_command(1'b0);

        drain();
        repeat (250) @(posedge clk);
        if (error_count == 0)
            $display("** first_fit_partition_allocator_unit: PASSED **");
        else
            $display("** first_fit_partition_allocator_unit: FAILED **");
        $finish;
    end

endmodule
